>>> hw/rtl/gray_scott_grid_step_defines.svh
// Assertion macros used by the checker file of the Gray-Scott grid block.
`ifndef GRAY_SCOTT_GRID_STEP_DEFINES_SVH
`define GRAY_SCOTT_GRID_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gray_scott_grid_step: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gray_scott_grid_step: check failed");

`endif

>>> hw/rtl/gsgrid_pkg.sv
// Types, codes and constants of the Gray-Scott grid block.
package gsgrid_pkg;

  localparam int REP_W = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_FEED = 2'd0,
    CFG_KILL = 2'd1,
    CFG_DU   = 2'd2,
    CFG_DV   = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    WS_HOST = 2'd0,
    WS_COPY = 2'd1,
    WS_CALC = 2'd2
  } wsrc_e;

  // stencil neighbor codes: center, edges, corners
  localparam logic [3:0] NB_C  = 4'd0;
  localparam logic [3:0] NB_N  = 4'd1;
  localparam logic [3:0] NB_S  = 4'd2;
  localparam logic [3:0] NB_W  = 4'd3;
  localparam logic [3:0] NB_E  = 4'd4;
  localparam logic [3:0] NB_NW = 4'd5;
  localparam logic [3:0] NB_NE = 4'd6;
  localparam logic [3:0] NB_SW = 4'd7;
  localparam logic [3:0] NB_SE = 4'd8;

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [15:0] RST_FEED = 16'd1311;
  localparam logic [15:0] RST_KILL = 16'd1966;
  localparam logic [15:0] RST_DU   = 16'd32768;
  localparam logic [15:0] RST_DV   = 16'd16384;

  localparam logic signed [53:0] FULL_SCALE = 54'sd20 <<< 45;
  localparam logic signed [53:0] HALF_DEN   = 54'sd10 <<< 30;
  localparam logic [21:0] RECIP_5 = 22'd3355444; // ceil(2^24 / 5)

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] u_in;
    logic [15:0] v_in;
    logic [3:0]  repeat_req;
  } in_t;

  typedef struct packed {
    logic [15:0] u_out;
    logic [15:0] v_out;
  } out_t;

  typedef struct packed {
    logic       in_load;
    logic       rd_host;
    logic       acc;
    logic [3:0] nb;
    logic       wr_en;
    wsrc_e      wsrc;
    logic       bank;
    logic       cell_next;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_e              op;
    logic             hit;
    logic [REP_W-1:0] rep;
  } sts_t;

  function automatic logic [15:0] sat_one(input logic [15:0] x);
    return (x > ONE_Q15) ? ONE_Q15 : x;
  endfunction

endpackage

>>> hw/rtl/gsgrid_dp.sv
// Datapath: cell memory, stencil gather, update pipeline, host and config registers.
module gsgrid_dp import gsgrid_pkg::*; #(
  parameter int GRID_W     = 64,
  parameter int GRID_H     = 64,
  parameter int MAX_REPEAT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_item_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output out_t        out_item_o
);

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(2 * CELLS);
  localparam int CIW   = $clog2(CELLS);

  logic [15:0] feed_q, kill_q, du_q, dv_q;
  logic [15:0] f_s, k_s, du_s, dv_s;

  op_e              op_q;
  logic             hit_q;
  logic [REP_W-1:0] rep_q;
  logic [AW-1:0]    hidx_q;
  logic [15:0]      hu_q, hv_q;
  logic [CIW-1:0]   cidx_q;

  logic [31:0] mem_q [2*CELLS];
  logic [31:0] rd_q;
  logic [AW-1:0] rd_base, wr_base, cell_a, off, raddr, waddr;
  logic [31:0] wdata;

  logic        acc_q;
  logic [3:0]  nb_q;
  logic [15:0] a_q, b_q;
  logic [17:0] eu_q, ev_q, cu_q, cv_q;

  // stage 1
  logic signed [21:0] lap_u_q, lap_v_q, lap_u_d, lap_v_d;
  logic [30:0] ab_q, fa_q;
  logic [31:0] kfb_q;
  logic [15:0] a1_q, b1_q;
  // stage 2
  logic [45:0] abb_q;
  logic signed [38:0] lu_q, lv_q;
  logic [30:0] fa2_q;
  logic [31:0] kfb2_q;
  logic [15:0] a2_q, b2_q;
  // stage 3
  logic signed [53:0] su_q, sv_q, su_d, sv_d;
  // stage 4
  logic [17:0] xu_q, xv_q;
  logic        zu_q, zv_q, ou_q, ov_q;
  logic signed [53:0] tu, tv;
  // stage 5
  logic [39:0] pu, pv;
  logic [15:0] ru_q, rv_q;

  out_t out_q;

  assign f_s  = sat_one(feed_q);
  assign k_s  = sat_one(kill_q);
  assign du_s = sat_one(du_q);
  assign dv_s = sat_one(dv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q <= RST_FEED;
      kill_q <= RST_KILL;
      du_q   <= RST_DU;
      dv_q   <= RST_DV;
      op_q   <= OP_WRITE;
      hit_q  <= 1'b0;
      rep_q  <= '0;
      cidx_q <= '0;
      acc_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_FEED: feed_q <= cfg_data_i;
          CFG_KILL: kill_q <= cfg_data_i;
          CFG_DU:   du_q   <= cfg_data_i;
          CFG_DV:   dv_q   <= cfg_data_i;
          default:  feed_q <= feed_q;
        endcase
      end
      if (cmd_i.in_load) begin
        op_q  <= op_e'(in_item_i.op);
        hit_q <= (32'(in_item_i.row) < GRID_H) && (32'(in_item_i.col) < GRID_W);
        rep_q <= (32'(in_item_i.repeat_req) > MAX_REPEAT) ? REP_W'(MAX_REPEAT)
                                                           : REP_W'(in_item_i.repeat_req);
      end
      if (cmd_i.cell_next) begin
        cidx_q <= (cidx_q == CIW'(CELLS - 1)) ? '0 : cidx_q + 1'b1;
      end
      acc_q <= cmd_i.acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      hidx_q <= AW'(AW'(in_item_i.row) * AW'(GRID_W)) + AW'(in_item_i.col);
      hu_q   <= sat_one(in_item_i.u_in);
      hv_q   <= sat_one(in_item_i.v_in);
    end
  end

  assign sts_o = '{op: op_q, hit: hit_q, rep: rep_q};

  // address generation; neighbor offsets wrap modulo the address width
  always_comb begin
    unique case (cmd_i.nb)
      NB_N:    off = '0 - AW'(GRID_W);
      NB_S:    off = AW'(GRID_W);
      NB_W:    off = '1;
      NB_E:    off = AW'(1);
      NB_NW:   off = '0 - AW'(GRID_W + 1);
      NB_NE:   off = '0 - AW'(GRID_W - 1);
      NB_SW:   off = AW'(GRID_W - 1);
      NB_SE:   off = AW'(GRID_W + 1);
      default: off = '0;
    endcase
  end

  assign rd_base = cmd_i.bank ? AW'(CELLS) : '0;
  assign wr_base = cmd_i.bank ? '0 : AW'(CELLS);
  assign cell_a  = AW'(cidx_q);
  assign raddr   = cmd_i.rd_host ? rd_base + hidx_q : rd_base + cell_a + off;
  assign waddr   = (cmd_i.wsrc == WS_HOST) ? rd_base + hidx_q : wr_base + cell_a;

  always_comb begin
    unique case (cmd_i.wsrc)
      WS_HOST: wdata = {hu_q, hv_q};
      WS_COPY: wdata = rd_q;
      WS_CALC: wdata = {ru_q, rv_q};
      default: wdata = rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // stencil gather, one word per cycle
  always_ff @(posedge clk_i) begin
    nb_q <= cmd_i.nb;
    if (acc_q) begin
      unique case (nb_q)
        NB_C: begin
          a_q  <= rd_q[31:16];
          b_q  <= rd_q[15:0];
          eu_q <= '0;
          ev_q <= '0;
          cu_q <= '0;
          cv_q <= '0;
        end
        NB_N, NB_S, NB_W, NB_E: begin
          eu_q <= eu_q + 18'(rd_q[31:16]);
          ev_q <= ev_q + 18'(rd_q[15:0]);
        end
        default: begin
          cu_q <= cu_q + 18'(rd_q[31:16]);
          cv_q <= cv_q + 18'(rd_q[15:0]);
        end
      endcase
    end
  end

  // 20 * Laplacian: -20*x + 4*edges + corners
  assign lap_u_d = $signed({2'b00, eu_q, 2'b00}) + $signed({4'b0000, cu_q})
                 - $signed(22'(a_q) * 22'd20);
  assign lap_v_d = $signed({2'b00, ev_q, 2'b00}) + $signed({4'b0000, cv_q})
                 - $signed(22'(b_q) * 22'd20);

  always_ff @(posedge clk_i) begin
    lap_u_q <= lap_u_d;
    lap_v_q <= lap_v_d;
    ab_q    <= 31'(32'(a_q) * 32'(b_q));
    fa_q    <= 31'(32'(f_s) * 32'(17'(ONE_Q15) - 17'(a_q)));
    kfb_q   <= 32'((33'(k_s) + 33'(f_s)) * 33'(b_q));
    a1_q    <= a_q;
    b1_q    <= b_q;

    abb_q  <= 46'(ab_q) * 46'(b1_q);
    lu_q   <= 39'(signed'({1'b0, du_s})) * 39'(lap_u_q);
    lv_q   <= 39'(signed'({1'b0, dv_s})) * 39'(lap_v_q);
    fa2_q  <= fa_q;
    kfb2_q <= kfb_q;
    a2_q   <= a1_q;
    b2_q   <= b1_q;

    su_q <= su_d;
    sv_q <= sv_d;
  end

  assign su_d = 54'sd20 * ((54'(a2_q) <<< 30) + (54'(fa2_q) <<< 15) - 54'(abb_q))
              + (54'(lu_q) <<< 15);
  assign sv_d = 54'sd20 * ((54'(b2_q) <<< 30) + 54'(abb_q) - (54'(kfb2_q) <<< 15))
              + (54'(lv_q) <<< 15);

  // round: (s + den/2) / (20 * 2^30) = ((s + den/2) >> 32) / 5
  assign tu = su_q + HALF_DEN;
  assign tv = sv_q + HALF_DEN;
  assign pu = 40'(xu_q) * 40'(RECIP_5);
  assign pv = 40'(xv_q) * 40'(RECIP_5);

  always_ff @(posedge clk_i) begin
    zu_q <= (su_q <= 0);
    zv_q <= (sv_q <= 0);
    ou_q <= (su_q >= FULL_SCALE);
    ov_q <= (sv_q >= FULL_SCALE);
    xu_q <= tu[49:32];
    xv_q <= tv[49:32];

    ru_q <= zu_q ? '0 : (ou_q ? ONE_Q15 : pu[39:24]);
    rv_q <= zv_q ? '0 : (ov_q ? ONE_Q15 : pv[39:24]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= hit_q ? out_t'(rd_q) : '0;
    end
  end

  assign out_item_o = out_q;

endmodule

>>> hw/rtl/gsgrid_ctrl.sv
// Controller: op sequencing, grid scan, bank select and output valid.
module gsgrid_ctrl import gsgrid_pkg::*; #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int RW = $clog2(GRID_H);
  localparam int CW = $clog2(GRID_W);
  localparam logic [2:0] CALC_LAT = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_HWR, S_CELL, S_GATHER, S_CALC, S_WRITE, S_CWR, S_HRD, S_HRSP
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       k_q, k_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [RW-1:0]    r_q, r_d;
  logic [CW-1:0]    c_q, c_d;
  logic [REP_W-1:0] it_q, it_d;
  logic             bank_q, bank_d;
  logic             outv_q, outv_d;
  logic             advance, border, last_col, last_row;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = outv_q;
  assign last_col = (c_q == CW'(GRID_W - 1));
  assign last_row = (r_q == RW'(GRID_H - 1));
  assign border   = (r_q == '0) || last_row || (c_q == '0) || last_col;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    c_d     = c_q;
    it_d    = it_q;
    bank_d  = bank_q;
    outv_d  = outv_q && !out_ready_i;
    advance = 1'b0;
    cmd_o   = '0;
    cmd_o.bank = bank_q;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_load = in_valid_i;
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        r_d  = '0;
        c_d  = '0;
        it_d = '0;
        unique case (sts_i.op)
          OP_WRITE: state_d = S_HWR;
          OP_RUN:   state_d = (sts_i.rep == '0) ? S_HRD : S_CELL;
          default:  state_d = S_HRD;
        endcase
      end
      S_HWR: begin
        cmd_o.wr_en = sts_i.hit;
        cmd_o.wsrc  = WS_HOST;
        state_d = S_HRD;
      end
      S_CELL: begin
        cmd_o.acc = 1'b1;
        cmd_o.nb  = NB_C;
        k_d = NB_N;
        state_d = border ? S_CWR : S_GATHER;
      end
      S_GATHER: begin
        cmd_o.acc = 1'b1;
        cmd_o.nb  = k_q;
        k_d = k_q + 1'b1;
        cnt_d = '0;
        if (k_q == NB_SE) state_d = S_CALC;
      end
      S_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CALC_LAT - 1'b1) state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsrc  = WS_CALC;
        advance = 1'b1;
      end
      S_CWR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsrc  = WS_COPY;
        advance = 1'b1;
      end
      S_HRD: begin
        cmd_o.rd_host = 1'b1;
        state_d = S_HRSP;
      end
      S_HRSP: begin
        // read address held so the read word stays put while the output is full
        cmd_o.rd_host = 1'b1;
        if (!outv_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          outv_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (advance) begin
      cmd_o.cell_next = 1'b1;
      state_d = S_CELL;
      if (last_col) begin
        c_d = '0;
        if (last_row) begin
          r_d    = '0;
          bank_d = ~bank_q;
          it_d   = it_q + 1'b1;
          if (it_q + 1'b1 == sts_i.rep) state_d = S_HRD;
        end else begin
          r_d = r_q + 1'b1;
        end
      end else begin
        c_d = c_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      r_q     <= '0;
      c_q     <= '0;
      it_q    <= '0;
      bank_q  <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      c_q     <= c_d;
      it_q    <= it_d;
      bank_q  <= bank_d;
      outv_q  <= outv_d;
    end
  end

endmodule

>>> hw/rtl/gray_scott_grid_step.sv
// Top level of the Gray-Scott reaction-diffusion grid block.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    in_item_i  (in_t)
//   out      output     out_valid_o / out_ready_i  out_item_o (out_t)
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A write item passes through dispatch, host write and host read-back; a read item
// skips the host write. A run item, per iteration, gathers each interior cell (nine
// memory reads), waits out the update pipeline and writes the result; each border
// cell is copied unchanged to the other bank.
// Reset clears control and bank select; config gets defaults, cell memory is kept.
// A full output register stalls only the final result; the next item is taken
// once the result is loaded.
module gray_scott_grid_step import gsgrid_pkg::*; #(
  parameter int GRID_W     = 64,
  parameter int GRID_H     = 64,
  parameter int MAX_REPEAT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  gsgrid_ctrl #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gsgrid_dp #(
    .GRID_W    (GRID_W),
    .GRID_H    (GRID_H),
    .MAX_REPEAT(MAX_REPEAT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

>>> hw/rtl/gsgrid_chk.sv
// Port-level checker for the Gray-Scott grid block, bound to the top level.
`include "gray_scott_grid_step_defines.svh"

module gsgrid_chk import gsgrid_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_item_o
);

  // a stalled result holds
  `GS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_item_o))

  // one item in flight: ready drops right after an accept
  `GS_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a new result appears together with the return to idle
  `GS_ASSERT_NOW(a_result_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)

endmodule

bind gray_scott_grid_step gsgrid_chk u_chk (.*);
